FILE: hdl/isl_pkg.sv
// Shared types and constants for the indexed shift list.
// Item structs, action and status codes, and controller command signals.
// No dependencies.
package isl_pkg;

	// Store geometry
	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 64;
	localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	// Fixed field widths of the item structs
	localparam int ACT_BITS  = 3;
	localparam int POS_BITS  = 4;
	localparam int DATA_BITS = 64;
	localparam int STAT_BITS = 2;
	localparam int OCNT_BITS = 5;

	// Width used to compare positions against the live count
	localparam int CMP_BITS  = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

	typedef enum logic [ACT_BITS-1:0] {
		ACT_APPEND    = 3'd0,
		ACT_INSERT    = 3'd1,
		ACT_ERASE     = 3'd2,
		ACT_OVERWRITE = 3'd3,
		ACT_READ      = 3'd4,
		ACT_CLEAR     = 3'd5
	} action_t;

	typedef enum logic [STAT_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [ACT_BITS-1:0]  action;
		logic [POS_BITS-1:0]  position;
		logic [DATA_BITS-1:0] word_in;
	} in_item_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] word_out;
		logic [STAT_BITS-1:0] status;
		logic [OCNT_BITS-1:0] count;
		logic                 is_empty;
	} out_item_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} ctl_cmd_t;

endpackage

FILE: hdl/isl_ctrl.sv
// Controller for the indexed shift list: idle/execute state machine.
// Issues capture and execute commands to the datapath and drives busy and done.
// Depends on isl_pkg.
module isl_ctrl import isl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output ctl_cmd_t cmd_o
);

	state_t state_q;
	state_t state_nx;
	logic   done_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd_o.capture = 1'b0;
		cmd_o.exec    = 1'b0;
		busy          = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_o.capture = start;
			end
			S_EXEC: begin
				cmd_o.exec = 1'b1;
				busy       = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// State and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= cmd_o.exec;
		end
	end

	assign done = done_q;

endmodule

FILE: hdl/isl_dpath.sv
// Datapath for the indexed shift list: row of word cells, live count, result register.
// Each cell takes its own word, a neighbor's word or the new word on each execute command.
// Depends on isl_pkg.
module isl_dpath import isl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_cmd_t  cmd_i,
	input  in_item_t  item,
	output out_item_t rsp
);

	typedef enum logic [1:0] {
		LN_HOLD = 2'd0,
		LN_NEW  = 2'd1,
		LN_UP   = 2'd2,
		LN_DOWN = 2'd3
	} lane_sel_t;

	in_item_t             item_q;
	logic [WORD_BITS-1:0] cells_q [DEPTH];
	logic [WORD_BITS-1:0] below_w [DEPTH];
	logic [WORD_BITS-1:0] above_w [DEPTH];
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  count_nx;
	out_item_t            rsp_q;
	lane_sel_t            sel [DEPTH];
	status_t              st;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] new_word;
	logic [CMP_BITS-1:0]  pos_c;
	logic [CMP_BITS-1:0]  cnt_c;
	logic [IDX_BITS-1:0]  rd_idx;
	logic                 full;

	// Neighbor words for shifting up and down
	for (genvar g = 0; g < DEPTH; g++) begin : g_lane
		if (g == 0) begin : g_first
			assign below_w[g] = '0;
		end else begin : g_rest
			assign below_w[g] = cells_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign above_w[g] = '0;
		end else begin : g_inner
			assign above_w[g] = cells_q[g+1];
		end
	end

	assign pos_c    = CMP_BITS'(item_q.position);
	assign cnt_c    = CMP_BITS'(count_q);
	assign rd_idx   = pos_c[IDX_BITS-1:0];
	assign full     = (count_q == CNT_BITS'(DEPTH));
	assign new_word = item_q.word_in[WORD_BITS-1:0];

	// Decode the action into lane selects, status and the next count
	always_comb begin
		st       = ST_OK;
		count_nx = count_q;
		rd_word  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel[i] = LN_HOLD;
		end
		unique case (item_q.action)
			ACT_APPEND: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (CMP_BITS'(i) == cnt_c) begin
							sel[i] = LN_NEW;
						end
					end
					count_nx = count_q + 1'b1;
				end
			end
			ACT_INSERT: begin
				if (pos_c > cnt_c) begin
					st = ST_RANGE;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (CMP_BITS'(i) == pos_c) begin
							sel[i] = LN_NEW;
						end else if (CMP_BITS'(i) > pos_c && CMP_BITS'(i) <= cnt_c) begin
							sel[i] = LN_UP;
						end
					end
					count_nx = count_q + 1'b1;
				end
			end
			ACT_ERASE: begin
				if (pos_c >= cnt_c) begin
					st = ST_RANGE;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (CMP_BITS'(i) >= pos_c && CMP_BITS'(i) + 1'b1 < cnt_c) begin
							sel[i] = LN_DOWN;
						end
					end
					count_nx = count_q - 1'b1;
				end
			end
			ACT_OVERWRITE: begin
				if (pos_c >= cnt_c) begin
					st = ST_RANGE;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (CMP_BITS'(i) == pos_c) begin
							sel[i] = LN_NEW;
						end
					end
				end
			end
			ACT_READ: begin
				if (pos_c >= cnt_c) begin
					st = ST_RANGE;
				end else begin
					rd_word = cells_q[rd_idx];
				end
			end
			ACT_CLEAR: begin
				count_nx = '0;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd_i.capture) begin
			item_q <= item;
		end
	end

	// Shift, write or hold each cell
	always_ff @(posedge clk) begin
		if (cmd_i.exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				unique case (sel[i])
					LN_NEW:  cells_q[i] <= new_word;
					LN_UP:   cells_q[i] <= below_w[i];
					LN_DOWN: cells_q[i] <= above_w[i];
					default: cells_q[i] <= cells_q[i];
				endcase
			end
		end
	end

	// Advance the live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd_i.exec) begin
			count_q <= count_nx;
		end
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (cmd_i.exec) begin
			rsp_q.word_out <= DATA_BITS'(rd_word);
			rsp_q.status   <= st;
			rsp_q.count    <= OCNT_BITS'(count_nx);
			rsp_q.is_empty <= (count_nx == '0);
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: hdl/indexed_shift_list.sv
// Indexed shift list: an ordered list of up to DEPTH words with append, insert,
// erase, overwrite, read and clear. Each item has a capture step, in which the
// command is registered, then an execute step, in which the cell row shifts or
// writes and the result register loads. busy is high during the execute cycle;
// start is taken when busy is low. The result appears one cycle after the
// execute cycle, marked by a single-cycle done strobe, and must be taken then
// since it is not held. Depends on isl_pkg, isl_ctrl and isl_dpath.
module indexed_shift_list import isl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  cmd,
	output logic      done,
	output out_item_t rsp
);

	ctl_cmd_t ctl;

	isl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd_o  (ctl)
	);

	isl_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_i  (ctl),
		.item   (cmd),
		.rsp    (rsp)
	);

endmodule

FILE: hdl/isl_checker.sv
// Port-level checks for the indexed shift list, bound to the top level.
// Depends on isl_pkg.
module isl_checker import isl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_item_t  cmd,
	input logic      done,
	input out_item_t rsp
);

	// An accepted item occupies the block for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// After the execute cycle busy drops and exactly one result is strobed
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("execute cycle did not produce a result");

	// Empty flag agrees with the count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.is_empty == (rsp.count == '0)))
		else $error("is_empty disagrees with count");

	// Count stays within the store depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.count <= OCNT_BITS'(DEPTH)))
		else $error("count beyond store depth");

	// A full refusal reports a full store
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == ST_FULL) |-> (rsp.count == OCNT_BITS'(DEPTH)))
		else $error("full status with store not full");

endmodule

bind indexed_shift_list isl_checker u_isl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.rsp    (rsp)
);

FILE: tb/tb.sv
// Self-checking testbench for indexed_shift_list: directed table, then random items.
// Expected results come from an in-bench list predictor or the directed table's typed-in values, checked in order.
// Depends on isl_pkg and the indexed_shift_list RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import isl_pkg::*;

	// Action codes the block decodes as no-ops
	localparam logic [ACT_BITS-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACT_BITS-1:0] ACT_SPARE_B = 3'd7;

	localparam int RANDOM_ITEMS = 750;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IN_BITS      = $bits(in_item_t);

	typedef struct {
		logic [ACT_BITS-1:0]  act;
		logic [POS_BITS-1:0]  pos;
		logic [DATA_BITS-1:0] word;
		int                   reps;
		bit                   pinned;
		out_item_t            want;
	} step_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  cmd;
	logic      done;
	out_item_t rsp;

	// Typed-in expectation travelling with the item on cmd
	bit        cur_pinned;
	out_item_t cur_want;

	// Predictor state: list contents and live length
	logic [WORD_BITS-1:0] list_cells [DEPTH];
	int                   list_len = 0;

	out_item_t pending_rsp [$];
	step_t     steps [$];

	int errors       = 0;
	int items_taken  = 0;
	int rsp_checked  = 0;
	int range_seen   = 0;
	int full_seen    = 0;
	int cycle_cnt    = 0;

	indexed_shift_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one item to the predicted list and return its response
	function automatic out_item_t list_apply(in_item_t it);
		out_item_t r;
		logic [WORD_BITS-1:0] w;
		int pos;
		w = it.word_in[WORD_BITS-1:0];
		pos = int'(it.position);
		r = '0;
		r.status = ST_OK;
		case (it.action)
			ACT_APPEND: begin
				if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					list_cells[list_len] = w;
					list_len++;
				end
			end
			ACT_INSERT: begin
				if (pos > list_len) begin
					r.status = ST_RANGE;
				end else if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = list_len; i > pos; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[pos] = w;
					list_len++;
				end
			end
			ACT_ERASE: begin
				if (pos >= list_len) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = pos + 1; i < list_len; i++)
						list_cells[i-1] = list_cells[i];
					list_len--;
				end
			end
			ACT_OVERWRITE: begin
				if (pos >= list_len)
					r.status = ST_RANGE;
				else
					list_cells[pos] = w;
			end
			ACT_READ: begin
				if (pos >= list_len)
					r.status = ST_RANGE;
				else
					r.word_out = DATA_BITS'(list_cells[pos]);
			end
			ACT_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		r.count = OCNT_BITS'(list_len);
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	function automatic out_item_t mk_resp(logic [DATA_BITS-1:0] w, status_t st, int n);
		out_item_t r;
		r.word_out = w;
		r.status = st;
		r.count = OCNT_BITS'(n);
		r.is_empty = (n == 0);
		return r;
	endfunction

	function automatic void add_step(logic [ACT_BITS-1:0] act, logic [POS_BITS-1:0] pos,
			logic [DATA_BITS-1:0] word, int reps, bit pinned, out_item_t want);
		step_t s;
		s.act = act;
		s.pos = pos;
		s.word = word;
		s.reps = reps;
		s.pinned = pinned;
		s.want = want;
		steps.push_back(s);
	endfunction

	function automatic logic [DATA_BITS-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		else if (r < 30)
			return 64'd1 << $urandom_range(0, 63);
		return {$urandom, $urandom};
	endfunction

	// Growth phases favor append and insert, shrink phases favor erase
	function automatic logic [ACT_BITS-1:0] pick_action(bit grow);
		int r;
		r = $urandom_range(0, 99);
		if (grow) begin
			if (r < 35) return ACT_APPEND;
			if (r < 60) return ACT_INSERT;
			if (r < 68) return ACT_ERASE;
			if (r < 78) return ACT_OVERWRITE;
			if (r < 95) return ACT_READ;
			if (r < 97) return ACT_CLEAR;
		end else begin
			if (r < 10) return ACT_APPEND;
			if (r < 18) return ACT_INSERT;
			if (r < 58) return ACT_ERASE;
			if (r < 70) return ACT_OVERWRITE;
			if (r < 92) return ACT_READ;
			if (r < 96) return ACT_CLEAR;
		end
		return $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
	endfunction

	// Sender pacing: bursts of back-to-back items, then a gap unless gaps are switched off
	int  burst_left = 0;
	bit  no_gaps    = 0;

	task automatic send_item(in_item_t it, bit pinned, out_item_t want);
		int gap;
		start <= 1'b1;
		cmd <= it;
		cur_pinned <= pinned;
		cur_want <= want;
		do @(posedge clk); while (busy);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			if ($urandom_range(0, 9) == 0)
				no_gaps = ~no_gaps;
			gap = no_gaps ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				// drop start and put junk on cmd while idle
				start <= 1'b0;
				cmd <= in_item_t'(IN_BITS'({$urandom, $urandom, $urandom}));
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Predict on each accepted item, check each strobed response
	always @(posedge clk) begin : mon
		out_item_t pred;
		out_item_t want;
		if (arst_n) begin
			if (start && !busy) begin
				pred = list_apply(cmd);
				pending_rsp.push_back(cur_pinned ? cur_want : pred);
				items_taken++;
			end
			if (done) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: response with none expected: word %h status %0d",
						$time, rsp.word_out, rsp.status);
					$display("%0t: unexpected response count %0d empty %0b",
						$time, rsp.count, rsp.is_empty);
					errors++;
				end else begin
					want = pending_rsp.pop_front();
					rsp_checked++;
					if (rsp.status == ST_RANGE) range_seen++;
					if (rsp.status == ST_FULL) full_seen++;
					if (rsp.word_out !== want.word_out) begin
						$display("%0t: word_out expected %h got %h", $time, want.word_out,
							rsp.word_out);
						errors++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status,
							rsp.status);
						errors++;
					end
					if (rsp.count !== want.count) begin
						$display("%0t: count expected %0d got %0d", $time, want.count,
							rsp.count);
						errors++;
					end
					if (rsp.is_empty !== want.is_empty) begin
						$display("%0t: is_empty expected %0b got %0b", $time, want.is_empty,
							rsp.is_empty);
						errors++;
					end
				end
			end
		end
	end

	// Hard stop on a hang
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin : stim
		in_item_t it;
		out_item_t none;
		bit grow;
		int phase_left;
		none = '0;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		cur_pinned <= 1'b0;
		cur_want <= '0;

		// Directed table: empty list, fill to full, refusals, shifts at both ends
		add_step(ACT_READ,      4'd0,  64'h0, 1, 1, mk_resp('0, ST_RANGE, 0));
		add_step(ACT_ERASE,     4'd15, 64'h0, 1, 1, mk_resp('0, ST_RANGE, 0));
		add_step(ACT_OVERWRITE, 4'd15, '1,    1, 1, mk_resp('0, ST_RANGE, 0));
		add_step(ACT_INSERT,    4'd1,  '1,    1, 1, mk_resp('0, ST_RANGE, 0));
		add_step(ACT_INSERT,    4'd0,  '1,    1, 1, mk_resp('0, ST_OK, 1));
		add_step(ACT_APPEND,    4'd15, 64'h0, 1, 1, mk_resp('0, ST_OK, 2));
		add_step(ACT_READ,      4'd0,  64'h0, 1, 1, mk_resp('1, ST_OK, 2));
		add_step(ACT_SPARE_A,   4'd0,  '1,    1, 1, mk_resp('0, ST_OK, 2));
		add_step(ACT_SPARE_B,   4'd15, '1,    1, 1, mk_resp('0, ST_OK, 2));
		add_step(ACT_APPEND,    4'd0,  64'h0, 14, 0, none);
		add_step(ACT_APPEND,    4'd0,  '1,    1, 1, mk_resp('0, ST_FULL, 16));
		add_step(ACT_INSERT,    4'd15, '1,    1, 1, mk_resp('0, ST_FULL, 16));
		add_step(ACT_INSERT,    4'd0,  '1,    1, 1, mk_resp('0, ST_FULL, 16));
		add_step(ACT_READ,      4'd15, 64'h0, 1, 0, none);
		add_step(ACT_ERASE,     4'd15, 64'h0, 1, 0, none);
		add_step(ACT_ERASE,     4'd0,  64'h0, 1, 0, none);
		add_step(ACT_INSERT,    4'd0,  64'h8000_0000_0000_0001, 1, 0, none);
		add_step(ACT_INSERT,    4'd15, 64'h0123_4567_89ab_cdef, 1, 0, none);
		add_step(ACT_OVERWRITE, 4'd15, 64'h0, 1, 0, none);
		add_step(ACT_READ,      4'd15, 64'h0, 1, 1, mk_resp('0, ST_OK, 16));
		add_step(ACT_ERASE,     4'd15, 64'h0, 1, 0, none);
		add_step(ACT_CLEAR,     4'd7,  '1,    1, 1, mk_resp('0, ST_OK, 0));
		add_step(ACT_READ,      4'd0,  64'h0, 1, 1, mk_resp('0, ST_RANGE, 0));

		// Hold reset, then release on a clock edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[k]) begin
			for (int n = 0; n < steps[k].reps; n++) begin
				it.action = steps[k].act;
				it.position = steps[k].pos;
				it.word_in = (steps[k].reps > 1) ? pick_word() : steps[k].word;
				send_item(it, steps[k].pinned, steps[k].want);
			end
		end

		// Random items in alternating growth and shrink phases
		grow = 1'b1;
		phase_left = $urandom_range(20, 60);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				grow = ~grow;
				phase_left = $urandom_range(20, 60);
			end
			phase_left--;
			it.action = pick_action(grow);
			it.position = POS_BITS'($urandom_range(0, 15));
			it.word_in = pick_word();
			send_item(it, 1'b0, none);
		end
		start <= 1'b0;

		// Drain outstanding responses, then let the pipeline settle
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d items accepted, %0d responses checked", items_taken, rsp_checked);
		$display("tb: refusals seen: %0d out of range, %0d full", range_seen, full_seen);
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
